// ===== src/ssr_pkg.sv =====
// Shared constants and types for the shadow return stack.
`default_nettype none
package ssr_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 256;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int FILL_W      = $clog2(STACK_DEPTH + 1);

    // Item field widths
    localparam int DATA_W      = 64;
    localparam int STATUS_W    = 3;
    localparam int FILL_OUT_W  = 9;
    localparam int CNT_W       = 32;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_UNDERFLOW = 3'd1;
    localparam t_status ST_RESYNC    = 3'd2;
    localparam t_status ST_MISMATCH  = 3'd3;
    localparam t_status ST_DROPPED   = 3'd4;

    localparam logic OP_CALL = 1'b0;
    localparam logic OP_RET  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_POP  = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

endpackage : ssr_pkg
`default_nettype wire

// ===== src/shadow_stack_with_resync_core.sv =====
// Top level of the shadow return stack with resync search.
`default_nettype none
// Shadow return stack. Each input item is a call (push its return address)
// or a return (pop and check against the actual target). The stack lives in
// one synchronous RAM of STACK_DEPTH x 64 bits; the fill level and three
// saturating counters sit in flops. Every item yields exactly one result
// item, held in an output register so a new item can be accepted while the
// previous result waits. A call, an underflow or a dropped push is settled
// on acceptance; a return first reads and compares the top entry (one RAM
// read). A return that misses scans downward one entry per cycle through
// the RAM read port, comparing entries below the popped one (up to the
// remaining fill). A match cuts the stack below the found entry (resync);
// no match leaves only the popped entry removed (mismatch). The RAM needs
// no clearing: only read data from entries below the fill level is used.
// One item is in work at a time.
module shadow_stack_with_resync_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input items
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic                           i_operation,
    input  wire logic [ssr_pkg::DATA_W-1:0]     i_address,
    // result items
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic      [ssr_pkg::STATUS_W-1:0]   o_status,
    output logic      [ssr_pkg::DATA_W-1:0]     o_expected_address,
    output logic      [ssr_pkg::FILL_OUT_W-1:0] o_stack_fill,
    output logic      [ssr_pkg::CNT_W-1:0]      o_underflow_total,
    output logic      [ssr_pkg::CNT_W-1:0]      o_resync_total,
    output logic      [ssr_pkg::CNT_W-1:0]      o_mismatch_total
);

    // control state
    ssr_pkg::t_state               r_state, n_state;
    logic [ssr_pkg::FILL_W-1:0]    r_fill,  n_fill;
    logic                          r_out_valid;

    // item in work (payload, no reset)
    logic [ssr_pkg::DATA_W-1:0]    r_addr,  n_addr;
    logic [ssr_pkg::ADDR_W-1:0]    r_idx,   n_idx;   // rdata holds entry r_idx-1 in scan
    ssr_pkg::t_status              r_status, n_status;
    logic [ssr_pkg::DATA_W-1:0]    r_expected, n_expected;

    // output register
    ssr_pkg::t_status              r_o_status;
    logic [ssr_pkg::DATA_W-1:0]    r_o_expected;
    logic [ssr_pkg::FILL_OUT_W-1:0] r_o_fill;
    logic [ssr_pkg::CNT_W-1:0]     r_o_under, r_o_resync, r_o_mis;

    // RAM port
    logic                          ram_we;
    logic [ssr_pkg::ADDR_W-1:0]    ram_waddr;
    logic [ssr_pkg::ADDR_W-1:0]    ram_raddr;
    logic [ssr_pkg::DATA_W-1:0]    ram_rdata;

    // counters
    logic                          inc_under, inc_resync, inc_mis;
    logic [ssr_pkg::CNT_W-1:0]     cnt_under, cnt_resync, cnt_mis;

    logic [ssr_pkg::FILL_W-1:0]    fill_dec;
    logic [ssr_pkg::ADDR_W-1:0]    idx_dec;
    logic                          stack_full;
    logic                          out_free;
    logic                          hit;

    assign fill_dec   = r_fill - ssr_pkg::FILL_W'(1);
    assign idx_dec    = r_idx - ssr_pkg::ADDR_W'(1);
    assign stack_full = (r_fill == ssr_pkg::FILL_W'(ssr_pkg::STACK_DEPTH));
    assign out_free   = !r_out_valid || i_out_ready;
    assign hit        = (ram_rdata == r_addr);
    assign ram_waddr  = r_fill[ssr_pkg::ADDR_W-1:0];

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_addr     = r_addr;
        n_idx      = r_idx;
        n_status   = r_status;
        n_expected = r_expected;
        ram_we     = 1'b0;
        ram_raddr  = fill_dec[ssr_pkg::ADDR_W-1:0];
        inc_under  = 1'b0;
        inc_resync = 1'b0;
        inc_mis    = 1'b0;

        unique case (r_state)
            ssr_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_addr     = i_address;
                    n_expected = '0;
                    n_status   = ssr_pkg::ST_OK;
                    if (i_operation == ssr_pkg::OP_CALL) begin
                        if (stack_full) begin
                            n_status = ssr_pkg::ST_DROPPED;
                        end else begin
                            ram_we = 1'b1;
                            n_fill = r_fill + ssr_pkg::FILL_W'(1);
                        end
                        n_state = ssr_pkg::S_DONE;
                    end else if (r_fill == '0) begin
                        inc_under = 1'b1;
                        n_status  = ssr_pkg::ST_UNDERFLOW;
                        n_state   = ssr_pkg::S_DONE;
                    end else begin
                        // read top entry, pop it
                        n_fill  = fill_dec;
                        n_state = ssr_pkg::S_POP;
                    end
                end
            end
            ssr_pkg::S_POP: begin
                n_expected = ram_rdata;
                if (hit) begin
                    n_state = ssr_pkg::S_DONE;
                end else if (r_fill == '0) begin
                    inc_mis  = 1'b1;
                    n_status = ssr_pkg::ST_MISMATCH;
                    n_state  = ssr_pkg::S_DONE;
                end else begin
                    // start downward scan at the entry below the popped one
                    n_idx   = r_fill[ssr_pkg::ADDR_W-1:0];
                    n_state = ssr_pkg::S_SCAN;
                end
            end
            ssr_pkg::S_SCAN: begin
                ram_raddr = idx_dec - ssr_pkg::ADDR_W'(1);
                if (hit) begin
                    // cut stack: found entry and all above are gone
                    n_fill     = ssr_pkg::FILL_W'(idx_dec);
                    inc_resync = 1'b1;
                    n_status   = ssr_pkg::ST_RESYNC;
                    n_state    = ssr_pkg::S_DONE;
                end else if (r_idx == ssr_pkg::ADDR_W'(1)) begin
                    inc_mis  = 1'b1;
                    n_status = ssr_pkg::ST_MISMATCH;
                    n_state  = ssr_pkg::S_DONE;
                end else begin
                    n_idx = idx_dec;
                end
            end
            ssr_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = ssr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ssr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssr_pkg::S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if ((r_state == ssr_pkg::S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_idx      <= n_idx;
        r_status   <= n_status;
        r_expected <= n_expected;
        // counters were updated on the decision cycle, so they are current here
        if ((r_state == ssr_pkg::S_DONE) && out_free) begin
            r_o_status   <= r_status;
            r_o_expected <= r_expected;
            r_o_fill     <= ssr_pkg::FILL_OUT_W'(r_fill);
            r_o_under    <= cnt_under;
            r_o_resync   <= cnt_resync;
            r_o_mis      <= cnt_mis;
        end
    end

    ssr_ram #(
        .WIDTH (ssr_pkg::DATA_W),
        .DEPTH (ssr_pkg::STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_address),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ssr_sat_cnt u_under_cnt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_inc   (inc_under),
        .o_count (cnt_under)
    );

    ssr_sat_cnt u_resync_cnt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_inc   (inc_resync),
        .o_count (cnt_resync)
    );

    ssr_sat_cnt u_mis_cnt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_inc   (inc_mis),
        .o_count (cnt_mis)
    );

    assign o_in_ready         = (r_state == ssr_pkg::S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_status           = r_o_status;
    assign o_expected_address = r_o_expected;
    assign o_stack_fill       = r_o_fill;
    assign o_underflow_total  = r_o_under;
    assign o_resync_total     = r_o_resync;
    assign o_mismatch_total   = r_o_mis;

endmodule : shadow_stack_with_resync_core
`default_nettype wire

// ===== src/ssr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ssr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule : ssr_ram
`default_nettype wire

// ===== src/ssr_sat_cnt.sv =====
// Saturating event counter.
`default_nettype none
module ssr_sat_cnt (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_inc,
    output logic      [ssr_pkg::CNT_W-1:0] o_count
);

    logic [ssr_pkg::CNT_W-1:0] r_count;
    logic [ssr_pkg::CNT_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_inc && (r_count != {ssr_pkg::CNT_W{1'b1}})) begin
            n_count = r_count + ssr_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count = r_count;

endmodule : ssr_sat_cnt
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the shadow return stack core.
`timescale 1ns / 1ps
// Flow of the run:
//  - reset, then a directed table of calls and returns that
//    hits underflow, exact-match pops, resync to a deeper entry (also to the
//    upper one of two equal entries, and to the bottom entry) and mismatch;
//  - three random phases (sender idle 26 / receiver idle 76, then the other
//    way round, then no idling), each mostly well-formed call/return nesting
//    with some resync and mismatch returns, one burst that fills the stack
//    and pushes past full, and a full-depth scan right after;
//  - in the last phase the receiver stalls for a long stretch so the core
//    fills up and drops ready on its input.
// Every result item is compared field by field against a predictor that
// runs at the moment the input item is accepted (directed rows may give a typed-in result instead).
module tb;

    localparam int CLK_HALF       = 5;
    localparam int PHASE_ITEMS    = 460;
    localparam int HOLD_CYCLES    = 400;
    // Longest legal quiet stretch is the receiver hold plus a full-depth scan
    localparam int WATCHDOG_LIMIT = 5000;
    // Tail after the last result: a full-depth scan plus margin
    localparam int TAIL_CYCLES    = ssr_pkg::STACK_DEPTH + 50;

    typedef struct packed {
        ssr_pkg::t_status                 status;
        logic [ssr_pkg::DATA_W-1:0]       exp_addr;
        logic [ssr_pkg::FILL_OUT_W-1:0]   fill;
        logic [ssr_pkg::CNT_W-1:0]        uf_total;
        logic [ssr_pkg::CNT_W-1:0]        rs_total;
        logic [ssr_pkg::CNT_W-1:0]        mm_total;
    } t_stack_result;

    // One directed row: the item, and a typed-in result where it is obvious
    typedef struct packed {
        logic                             op;
        logic [ssr_pkg::DATA_W-1:0]       addr;
        logic                             typed;
        t_stack_result                    res;
    } t_dir_row;

    localparam t_stack_result NO_RES = '0;
    localparam logic [ssr_pkg::DATA_W-1:0] ALL1 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int DIR_N = 25;

    localparam t_dir_row DIR_TAB [DIR_N] = '{
        // empty stack: underflow on both address extremes
        '{ssr_pkg::OP_RET,  64'h0, 1'b1,
          '{ssr_pkg::ST_UNDERFLOW, 64'h0, 9'd0, 32'd1, 32'd0, 32'd0}},
        '{ssr_pkg::OP_RET,  ALL1,  1'b1,
          '{ssr_pkg::ST_UNDERFLOW, 64'h0, 9'd0, 32'd2, 32'd0, 32'd0}},
        // push and pop the extremes, exact matches
        '{ssr_pkg::OP_CALL, ALL1,  1'b1,
          '{ssr_pkg::ST_OK, 64'h0, 9'd1, 32'd2, 32'd0, 32'd0}},
        '{ssr_pkg::OP_CALL, 64'h0, 1'b1,
          '{ssr_pkg::ST_OK, 64'h0, 9'd2, 32'd2, 32'd0, 32'd0}},
        '{ssr_pkg::OP_RET,  64'h0, 1'b1,
          '{ssr_pkg::ST_OK, 64'h0, 9'd1, 32'd2, 32'd0, 32'd0}},
        '{ssr_pkg::OP_RET,  ALL1,  1'b1,
          '{ssr_pkg::ST_OK, ALL1,  9'd0, 32'd2, 32'd0, 32'd0}},
        // four deep, then return to the second entry: resync cuts to one
        '{ssr_pkg::OP_CALL, 64'h8000_0000_0000_0000, 1'b0, NO_RES},
        '{ssr_pkg::OP_CALL, 64'h0000_0000_0000_0001, 1'b0, NO_RES},
        '{ssr_pkg::OP_CALL, 64'h1111_0000_0000_1111, 1'b0, NO_RES},
        '{ssr_pkg::OP_CALL, 64'h2222_0000_0000_2222, 1'b0, NO_RES},
        '{ssr_pkg::OP_RET,  64'h0000_0000_0000_0001, 1'b0, NO_RES},
        // last entry popped against a foreign target: mismatch, stack empty
        '{ssr_pkg::OP_RET,  64'h0000_0000_DEAD_BEEF, 1'b0, NO_RES},
        '{ssr_pkg::OP_RET,  64'h0, 1'b1,
          '{ssr_pkg::ST_UNDERFLOW, 64'h0, 9'd0, 32'd3, 32'd1, 32'd1}},
        // duplicate entries: the search must stop at the upper one
        '{ssr_pkg::OP_CALL, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, NO_RES},
        '{ssr_pkg::OP_CALL, 64'h5555_5555_5555_5555, 1'b0, NO_RES},
        '{ssr_pkg::OP_CALL, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, NO_RES},
        '{ssr_pkg::OP_CALL, 64'h5555_5555_5555_5555, 1'b0, NO_RES},
        '{ssr_pkg::OP_RET,  64'hAAAA_AAAA_AAAA_AAAA, 1'b0, NO_RES},
        '{ssr_pkg::OP_RET,  64'h0000_0000_0000_1234, 1'b0, NO_RES},
        '{ssr_pkg::OP_RET,  64'hAAAA_AAAA_AAAA_AAAA, 1'b0, NO_RES},
        '{ssr_pkg::OP_CALL, 64'h0123_4567_89AB_CDEF, 1'b0, NO_RES},
        '{ssr_pkg::OP_RET,  64'h0123_4567_89AB_CDEF, 1'b0, NO_RES},
        // resync onto the bottom entry empties the stack
        '{ssr_pkg::OP_CALL, 64'h0000_7777_0000_7777, 1'b0, NO_RES},
        '{ssr_pkg::OP_CALL, 64'h0000_8888_0000_8888, 1'b0, NO_RES},
        '{ssr_pkg::OP_RET,  64'h0000_7777_0000_7777, 1'b0, NO_RES}
    };

    // DUT connections
    logic                             i_clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_op;
    logic [ssr_pkg::DATA_W-1:0]       in_addr;
    logic                             out_ready;
    wire                              o_in_ready;
    wire                              o_out_valid;
    wire [ssr_pkg::STATUS_W-1:0]      o_status;
    wire [ssr_pkg::DATA_W-1:0]        o_expected_address;
    wire [ssr_pkg::FILL_OUT_W-1:0]    o_stack_fill;
    wire [ssr_pkg::CNT_W-1:0]         o_underflow_total;
    wire [ssr_pkg::CNT_W-1:0]         o_resync_total;
    wire [ssr_pkg::CNT_W-1:0]         o_mismatch_total;

    shadow_stack_with_resync_core DUT (
        .i_clk              (i_clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (o_in_ready),
        .i_operation        (in_op),
        .i_address          (in_addr),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (out_ready),
        .o_status           (o_status),
        .o_expected_address (o_expected_address),
        .o_stack_fill       (o_stack_fill),
        .o_underflow_total  (o_underflow_total),
        .o_resync_total     (o_resync_total),
        .o_mismatch_total   (o_mismatch_total)
    );

    // Predictor state: its own copy of the stack and counters
    logic [ssr_pkg::DATA_W-1:0]       ref_store [ssr_pkg::STACK_DEPTH];
    int                               ref_fill;
    logic [ssr_pkg::CNT_W-1:0]        ref_uf;
    logic [ssr_pkg::CNT_W-1:0]        ref_rs;
    logic [ssr_pkg::CNT_W-1:0]        ref_mm;

    t_stack_result                    pending_results [$];

    // Shared between sender, receiver and watchdog (written with NBAs)
    int                      recv_idle_pct;
    logic                    hold_req;
    logic                    hold_done;
    int                      hold_left;
    int                      quiet_cycles;

    int                      err_cnt;
    int                      items_sent;
    int                      results_seen;
    int                      n_underflow;
    int                      n_resync;
    int                      n_mismatch;
    int                      n_dropped;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic logic [ssr_pkg::CNT_W-1:0] bump(input logic [ssr_pkg::CNT_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // Expected result of one accepted item; advances the predictor state.
    function automatic t_stack_result shadow_predict(input logic op,
                                                     input logic [ssr_pkg::DATA_W-1:0] a);
        t_stack_result r;
        int            i;
        bit            hit;
        r = '0;
        r.status = ssr_pkg::ST_OK;
        if (op == ssr_pkg::OP_CALL) begin
            if (ref_fill >= ssr_pkg::STACK_DEPTH) begin
                r.status = ssr_pkg::ST_DROPPED;
            end else begin
                ref_store[ref_fill] = a;
                ref_fill++;
            end
        end else if (ref_fill == 0) begin
            ref_uf = bump(ref_uf);
            r.status = ssr_pkg::ST_UNDERFLOW;
        end else begin
            ref_fill--;
            r.exp_addr = ref_store[ref_fill];
            if (r.exp_addr != a) begin
                // walk down below the popped entry; first hit wins
                hit = 1'b0;
                for (i = ref_fill; i > 0 && !hit; i--) begin
                    if (ref_store[i-1] == a) begin
                        ref_fill = i - 1;
                        hit = 1'b1;
                    end
                end
                if (hit) begin
                    ref_rs = bump(ref_rs);
                    r.status = ssr_pkg::ST_RESYNC;
                end else begin
                    ref_mm = bump(ref_mm);
                    r.status = ssr_pkg::ST_MISMATCH;
                end
            end
        end
        r.fill     = ssr_pkg::FILL_OUT_W'(ref_fill);
        r.uf_total = ref_uf;
        r.rs_total = ref_rs;
        r.mm_total = ref_mm;
        return r;
    endfunction

    function automatic logic [ssr_pkg::DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Random event shaped like a real call/return stream, steered by the
    // current predicted stack so that most returns hit or resync.
    function automatic void pick_event(output logic op,
                                       output logic [ssr_pkg::DATA_W-1:0] a);
        int r;
        r = $urandom_range(99);
        if (ref_fill == 0) begin
            op = (r < 15) ? ssr_pkg::OP_RET : ssr_pkg::OP_CALL;
            a  = rand64();
        end else if (r < 48) begin
            op = ssr_pkg::OP_CALL;
            // some calls reuse an address already on the stack
            a  = (r < 8) ? ref_store[$urandom_range(ref_fill - 1, 0)] : rand64();
        end else if (r < 86) begin
            op = ssr_pkg::OP_RET;
            a  = ref_store[ref_fill - 1];
        end else if (r < 94 && ref_fill >= 2) begin
            // skip frames: return into a deeper entry
            op = ssr_pkg::OP_RET;
            a  = ref_store[$urandom_range(ref_fill - 2, 0)];
        end else if (r < 97) begin
            // corrupted target, one bit off the real top
            op = ssr_pkg::OP_RET;
            a  = ref_store[ref_fill - 1] ^ (64'd1 << $urandom_range(ssr_pkg::DATA_W - 1));
        end else begin
            op = ssr_pkg::OP_RET;
            a  = rand64();
        end
    endfunction

    task automatic flag_error(input string what);
        $display("[%0t] mismatch at result %0d: %s", $realtime, results_seen, what);
        err_cnt++;
    endtask

    // Offer one item and hold it until accepted; returns on the accept edge
    // with valid still high, so a back-to-back item needs no toggle.
    task automatic send_item(input logic op, input logic [ssr_pkg::DATA_W-1:0] a,
                             input logic typed, input t_stack_result want);
        t_stack_result pred;
        in_valid <= 1'b1;
        in_op    <= op;
        in_addr  <= a;
        do @(posedge i_clk); while (!o_in_ready);
        pred = shadow_predict(op, a);
        pending_results.push_back(typed ? want : pred);
        items_sent++;
    endtask

    task automatic sender_gap(input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Sender, phase control and end of run
    initial begin : sender
        int                         ph;
        int                         n;
        int                         burst_at;
        int                         send_idle;
        logic                       op;
        logic [ssr_pkg::DATA_W-1:0] a;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_op         = ssr_pkg::OP_CALL;
        in_addr       = '0;
        recv_idle_pct = 76;
        hold_req      = 1'b0;
        err_cnt       = 0;
        items_sent    = 0;
        ref_fill      = 0;
        ref_uf        = '0;
        ref_rs        = '0;
        ref_mm        = '0;
        send_idle     = 26;

        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (n = 0; n < DIR_N; n++) begin
            sender_gap(send_idle);
            send_item(DIR_TAB[n].op, DIR_TAB[n].addr, DIR_TAB[n].typed, DIR_TAB[n].res);
        end

        // random phases
        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle = 26; recv_idle_pct <= 76; end
                1: begin send_idle = 76; recv_idle_pct <= 26; end
                default: begin send_idle = 0; recv_idle_pct <= 0; end
            endcase
            burst_at = $urandom_range(300, 100);
            n = 0;
            while (n < PHASE_ITEMS) begin
                if (ph == 2 && n == 60) begin
                    hold_req <= 1'b1;
                end
                if (n == burst_at) begin
                    // fill to the top, push past full, then scan the whole stack
                    while (ref_fill < ssr_pkg::STACK_DEPTH) begin
                        sender_gap(send_idle);
                        send_item(ssr_pkg::OP_CALL, rand64(), 1'b0, NO_RES);
                        n++;
                    end
                    repeat (1 + $urandom_range(3)) begin
                        sender_gap(send_idle);
                        send_item(ssr_pkg::OP_CALL, rand64(), 1'b0, NO_RES);
                        n++;
                    end
                    sender_gap(send_idle);
                    send_item(ssr_pkg::OP_RET, rand64(), 1'b0, NO_RES);
                    n++;
                end else begin
                    pick_event(op, a);
                    sender_gap(send_idle);
                    send_item(op, a, 1'b0, NO_RES);
                    n++;
                end
            end
        end
        in_valid <= 1'b0;

        // drain; the watchdog catches a result that never comes
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d items, checked %0d results: %0d underflow, %0d resync,",
                 items_sent, results_seen, n_underflow, n_resync);
        $display("%0d mismatch, %0d dropped pushes, under three idle mixes and a long stall.",
                 n_mismatch, n_dropped);
        if (err_cnt == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Receiver: random ready, one long hold-off, and the result check
    initial begin
        out_ready    = 1'b0;
        hold_done    = 1'b0;
        hold_left    = 0;
        results_seen = 0;
        n_underflow  = 0;
        n_resync     = 0;
        n_mismatch   = 0;
        n_dropped    = 0;
    end

    always @(posedge i_clk) begin
        t_stack_result want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (pending_results.size() == 0) begin
                    flag_error("result item with no item outstanding");
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status)
                        flag_error($sformatf("status %0d, want %0d", o_status, want.status));
                    if (o_expected_address !== want.exp_addr)
                        flag_error($sformatf("expected_address %h, want %h",
                                             o_expected_address, want.exp_addr));
                    if (o_stack_fill !== want.fill)
                        flag_error($sformatf("stack_fill %0d, want %0d",
                                             o_stack_fill, want.fill));
                    if (o_underflow_total !== want.uf_total)
                        flag_error($sformatf("underflow_total %0d, want %0d",
                                             o_underflow_total, want.uf_total));
                    if (o_resync_total !== want.rs_total)
                        flag_error($sformatf("resync_total %0d, want %0d",
                                             o_resync_total, want.rs_total));
                    if (o_mismatch_total !== want.mm_total)
                        flag_error($sformatf("mismatch_total %0d, want %0d",
                                             o_mismatch_total, want.mm_total));
                    case (want.status)
                        ssr_pkg::ST_UNDERFLOW: n_underflow <= n_underflow + 1;
                        ssr_pkg::ST_RESYNC:    n_resync    <= n_resync + 1;
                        ssr_pkg::ST_MISMATCH:  n_mismatch  <= n_mismatch + 1;
                        ssr_pkg::ST_DROPPED:   n_dropped   <= n_dropped + 1;
                        default: ;
                    endcase
                end
                results_seen <= results_seen + 1;
            end
            // long stall: the core backs up and must drop its input ready
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end else if (hold_req && !hold_done) begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: too many cycles with no handshake on either side
    initial quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule

// ===== files.f =====
src/ssr_pkg.sv
src/ssr_ram.sv
src/ssr_sat_cnt.sv
src/shadow_stack_with_resync_core.sv
verif/tb.sv
